// ===== rtl/uvcdw_pkg.sv =====
// ----------------------------------------------------------------------------
// uvcdw_pkg
// Shared types and constants for the UVC descriptor walker.
// ----------------------------------------------------------------------------
`default_nettype none

package uvcdw_pkg;

    // Descriptor codes
    localparam logic [7:0]  DT_INTERFACE           = 8'h04;
    localparam logic [7:0]  DT_CLASS_IFACE         = 8'h24;
    localparam logic [7:0]  SUB_INPUT_TERMINAL     = 8'h02;
    localparam logic [7:0]  SUB_EXTENSION_UNIT     = 8'h06;
    localparam logic [7:0]  CLASS_VIDEO            = 8'h0E;
    localparam logic [7:0]  SUBCLASS_VIDEO_CONTROL = 8'h01;
    localparam logic [15:0] TERMINAL_CAMERA        = 16'h0201;

    // Length limits and control bit position
    localparam int TERMINAL_BASE_LEN = 15;
    localparam int ZOOM_BIT          = 9;
    localparam int IFACE_MIN_LEN     = 9;
    localparam int UNIT_MIN_LEN      = 20;
    localparam int MIN_DESC_LEN      = 2;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GUID_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUID_HIGH = 1'b1;

    localparam logic [63:0] GUID_LOW_RESET  = 64'd5706312183290437328;
    localparam logic [63:0] GUID_HIGH_RESET = 64'd5204475402728215214;

    // One input beat
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } uvcdw_beat_t;

    // One result beat
    typedef struct packed {
        logic        xu_matched;
        logic [7:0]  xu_unit_id;
        logic [7:0]  xu_interface;
        logic        terminal_found;
        logic [7:0]  terminal_id;
        logic [15:0] focal_min;
        logic [15:0] focal_max;
        logic [15:0] ocular_focal;
        logic        zoom_supported;
        logic        malformed;
    } uvcdw_result_t;

    // Walker state
    typedef struct packed {
        logic [7:0]  pos;
        logic [7:0]  len;
        logic [7:0]  dtype;
        logic [7:0]  subtype;
        logic [15:0] term_type;
        logic [15:0] focal_min;
        logic [15:0] focal_max;
        logic [15:0] ocular;
        logic [7:0]  side_id;
        logic [7:0]  side_class;
        logic [7:0]  side_subclass;
        logic [7:0]  csize;
        logic [7:0]  ctrl1;
        logic        guid_match;
        logic        in_vc;
        logic [7:0]  vc_num;
        logic        unit_done;
        logic        term_done;
        logic        halted;
        logic        xu_matched;
        logic [7:0]  xu_id;
        logic [7:0]  xu_if;
        logic        t_found;
        logic [7:0]  t_id;
        logic [15:0] t_fmin;
        logic [15:0] t_fmax;
        logic [15:0] t_ocular;
        logic        t_zoom;
    } uvcdw_state_t;

    function automatic uvcdw_state_t state_reset();
        uvcdw_state_t s;
        s = '0;
        s.guid_match = 1'b1;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/uvcdw_in_stage.sv =====
// ----------------------------------------------------------------------------
// uvcdw_in_stage
// Input register: captures one descriptor byte beat per cycle while s_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module uvcdw_in_stage (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire uvcdw_pkg::uvcdw_beat_t s_beat,
    output logic                    beat_valid,
    output uvcdw_pkg::uvcdw_beat_t  beat,
    input  wire logic               beat_take
);

    logic                   valid_reg;
    uvcdw_pkg::uvcdw_beat_t beat_reg;

    // Free when empty or when the held beat leaves this cycle
    assign s_ready    = !valid_reg || beat_take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uvcdw_walk.sv =====
// ----------------------------------------------------------------------------
// uvcdw_walk
// Descriptor walker: splits bytes into descriptors, tracks the video-control
// interface and runs the extension-unit and camera-terminal searches.
// ----------------------------------------------------------------------------
`default_nettype none

module uvcdw_walk (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [127:0]           guid,
    input  wire logic                   beat_valid,
    input  wire uvcdw_pkg::uvcdw_beat_t beat,
    output logic                        beat_take,
    input  wire logic                   res_ready,
    output logic                        res_valid,
    output uvcdw_pkg::uvcdw_result_t    res
);

    uvcdw_pkg::uvcdw_state_t st_reg;
    uvcdw_pkg::uvcdw_state_t st_next;
    uvcdw_pkg::uvcdw_state_t upd;
    logic [3:0]              guid_idx;
    logic [7:0]              guid_byte;
    logic                    at_end;
    logic                    vc_match;

    // A last beat needs room in the result register
    assign beat_take = beat_valid && (!beat.last || res_ready);
    assign res_valid = beat_take && beat.last;

    // GUID byte for positions 4..19
    assign guid_idx  = 4'(st_reg.pos - 8'd4);
    assign guid_byte = guid[{guid_idx, 3'b000} +: 8];

    // Per-byte update of the walk state
    always_comb begin
        upd      = st_reg;
        at_end   = 1'b0;
        vc_match = 1'b0;
        if (!st_reg.halted) begin
            if (st_reg.pos == 8'd0) begin
                // Length byte opens a new descriptor
                upd.len           = beat.data;
                upd.dtype         = '0;
                upd.subtype       = '0;
                upd.term_type     = '0;
                upd.focal_min     = '0;
                upd.focal_max     = '0;
                upd.ocular        = '0;
                upd.side_id       = '0;
                upd.side_class    = '0;
                upd.side_subclass = '0;
                upd.csize         = '0;
                upd.ctrl1         = '0;
                upd.guid_match    = 1'b1;
                upd.pos           = 8'd1;
            end else begin
                at_end = 1'b1;
                if (st_reg.pos == 8'd1) begin
                    upd.dtype = beat.data;
                    if (st_reg.len < 8'(uvcdw_pkg::MIN_DESC_LEN)) begin
                        upd.unit_done = 1'b1;
                        upd.term_done = 1'b1;
                        upd.halted    = 1'b1;
                        at_end        = 1'b0;
                    end
                end else begin
                    case (st_reg.pos)
                        8'd2:  upd.subtype          = beat.data;
                        8'd3:  upd.side_id          = beat.data;
                        8'd4:  upd.term_type[7:0]   = beat.data;
                        8'd5: begin
                            upd.term_type[15:8] = beat.data;
                            upd.side_class      = beat.data;
                        end
                        8'd6:  upd.side_subclass    = beat.data;
                        8'd8:  upd.focal_min[7:0]   = beat.data;
                        8'd9:  upd.focal_min[15:8]  = beat.data;
                        8'd10: upd.focal_max[7:0]   = beat.data;
                        8'd11: upd.focal_max[15:8]  = beat.data;
                        8'd12: upd.ocular[7:0]      = beat.data;
                        8'd13: upd.ocular[15:8]     = beat.data;
                        8'd14: upd.csize            = beat.data;
                        8'd16: upd.ctrl1            = beat.data;
                        default: ;
                    endcase
                    if (st_reg.pos >= 8'd4 && st_reg.pos <= 8'd19 && beat.data != guid_byte) begin
                        upd.guid_match = 1'b0;
                    end
                end

                if (at_end) begin
                    if ({1'b0, st_reg.pos} + 9'd1 >= {1'b0, st_reg.len}) begin
                        // Descriptor complete: examine it
                        upd.pos = 8'd0;
                        if (upd.dtype == uvcdw_pkg::DT_INTERFACE &&
                            upd.len >= 8'(uvcdw_pkg::IFACE_MIN_LEN)) begin
                            vc_match = upd.side_class == uvcdw_pkg::CLASS_VIDEO &&
                                upd.side_subclass == uvcdw_pkg::SUBCLASS_VIDEO_CONTROL;
                            upd.in_vc = vc_match;
                            if (vc_match) begin
                                upd.vc_num = upd.subtype;
                            end
                        end else if (upd.dtype == uvcdw_pkg::DT_CLASS_IFACE) begin
                            if (!st_reg.unit_done && upd.guid_match &&
                                upd.len >= 8'(uvcdw_pkg::UNIT_MIN_LEN) &&
                                upd.subtype == uvcdw_pkg::SUB_EXTENSION_UNIT) begin
                                upd.xu_matched = 1'b1;
                                upd.xu_id      = upd.side_id;
                                upd.xu_if      = st_reg.in_vc ? st_reg.vc_num : 8'd0;
                                upd.unit_done  = 1'b1;
                            end
                            if (!st_reg.term_done &&
                                upd.len >= 8'(uvcdw_pkg::TERMINAL_BASE_LEN) &&
                                upd.subtype == uvcdw_pkg::SUB_INPUT_TERMINAL &&
                                upd.term_type == uvcdw_pkg::TERMINAL_CAMERA) begin
                                upd.term_done = 1'b1;
                                if (9'(uvcdw_pkg::TERMINAL_BASE_LEN) + {1'b0, upd.csize}
                                        <= {1'b0, upd.len}) begin
                                    upd.t_found  = 1'b1;
                                    upd.t_id     = upd.side_id;
                                    upd.t_fmin   = upd.focal_min;
                                    upd.t_fmax   = upd.focal_max;
                                    upd.t_ocular = upd.ocular;
                                    upd.t_zoom   = (upd.csize > 8'(uvcdw_pkg::ZOOM_BIT / 8)) &&
                                                   upd.ctrl1[uvcdw_pkg::ZOOM_BIT % 8];
                                end
                            end
                        end
                    end else begin
                        upd.pos = st_reg.pos + 8'd1;
                        // Stream ends inside a descriptor
                        if (beat.last) begin
                            upd.unit_done = 1'b1;
                            upd.term_done = 1'b1;
                            upd.halted    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Result fields from the updated state
    always_comb begin
        res.xu_matched     = upd.xu_matched;
        res.xu_unit_id     = upd.xu_id;
        res.xu_interface   = upd.xu_if;
        res.terminal_found = upd.t_found;
        res.terminal_id    = upd.t_id;
        res.focal_min      = upd.t_fmin;
        res.focal_max      = upd.t_fmax;
        res.ocular_focal   = upd.t_ocular;
        res.zoom_supported = upd.t_zoom;
        res.malformed      = upd.halted;
    end

    // Last beat starts a fresh stream
    assign st_next = beat.last ? uvcdw_pkg::state_reset() : upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= uvcdw_pkg::state_reset();
        end else if (beat_take) begin
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uvcdw_out_stage.sv =====
// ----------------------------------------------------------------------------
// uvcdw_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module uvcdw_out_stage (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     res_valid,
    output logic                          res_ready,
    input  wire uvcdw_pkg::uvcdw_result_t res,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output uvcdw_pkg::uvcdw_result_t      m_res
);

    logic                     valid_reg;
    uvcdw_pkg::uvcdw_result_t res_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/uvc_descriptor_walker.sv =====
// Result path: the last byte of a stream passes the input register, then
//   the result register, before m_valid rises; it waits longer only while
//   m_ready holds the previous result.
// Throughput: one descriptor byte per cycle; only a last byte waits for a
//   free result register.
// Reset: synchronous, active-low aresetn clears the walk state and both
//   handshakes; the GUID registers return to their default values.
// ----------------------------------------------------------------------------
// uvc_descriptor_walker
// Walks a USB configuration descriptor byte by byte and reports the matching
// extension unit and the camera terminal at the end of the stream.
// ----------------------------------------------------------------------------
`default_nettype none

module uvc_descriptor_walker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration
    input  wire logic                           cfg_wr_en,
    input  wire logic [uvcdw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                    cfg_wdata,
    // Byte input
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_descriptor_byte,
    input  wire logic                           s_last_byte,
    // Result output
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic                                m_xu_matched,
    output logic [7:0]                          m_xu_unit_id,
    output logic [7:0]                          m_xu_interface,
    output logic                                m_terminal_found,
    output logic [7:0]                          m_terminal_id,
    output logic [15:0]                         m_focal_min,
    output logic [15:0]                         m_focal_max,
    output logic [15:0]                         m_ocular_focal,
    output logic                                m_zoom_supported,
    output logic                                m_malformed
);

    logic [63:0]              guid_low_reg;
    logic [63:0]              guid_high_reg;
    uvcdw_pkg::uvcdw_beat_t   s_beat;
    uvcdw_pkg::uvcdw_beat_t   beat;
    logic                     beat_valid;
    logic                     beat_take;
    logic                     res_valid;
    logic                     res_ready;
    uvcdw_pkg::uvcdw_result_t res;
    uvcdw_pkg::uvcdw_result_t m_res;

    // GUID registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guid_low_reg  <= uvcdw_pkg::GUID_LOW_RESET;
            guid_high_reg <= uvcdw_pkg::GUID_HIGH_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                uvcdw_pkg::CFG_GUID_LOW:  guid_low_reg  <= cfg_wdata;
                uvcdw_pkg::CFG_GUID_HIGH: guid_high_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_beat.data = s_descriptor_byte;
    assign s_beat.last = s_last_byte;

    uvcdw_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    uvcdw_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .guid       ({guid_high_reg, guid_low_reg}),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    uvcdw_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_xu_matched     = m_res.xu_matched;
    assign m_xu_unit_id     = m_res.xu_unit_id;
    assign m_xu_interface   = m_res.xu_interface;
    assign m_terminal_found = m_res.terminal_found;
    assign m_terminal_id    = m_res.terminal_id;
    assign m_focal_min      = m_res.focal_min;
    assign m_focal_max      = m_res.focal_max;
    assign m_ocular_focal   = m_res.ocular_focal;
    assign m_zoom_supported = m_res.zoom_supported;
    assign m_malformed      = m_res.malformed;

endmodule

`default_nettype wire

// ===== rtl/uvcdw_checker.sv =====
// ----------------------------------------------------------------------------
// uvcdw_checker
// Port-level checks for the descriptor walker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uvcdw_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic                            m_xu_matched,
    input wire logic [7:0]                      m_xu_unit_id,
    input wire logic [7:0]                      m_xu_interface,
    input wire logic                            m_terminal_found,
    input wire logic [7:0]                      m_terminal_id,
    input wire logic [15:0]                     m_focal_min,
    input wire logic [15:0]                     m_focal_max,
    input wire logic [15:0]                     m_ocular_focal,
    input wire logic                            m_zoom_supported,
    input wire logic                            m_malformed
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat visible after reset");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_xu_unit_id) &&
            $stable(m_terminal_id) && $stable(m_focal_min) && $stable(m_malformed))
        else $error("stalled result beat changed");

    // With no result pending the input side always takes a beat
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Unit fields are zero without a find
    a_unit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_xu_matched |-> m_xu_unit_id == 8'd0 && m_xu_interface == 8'd0)
        else $error("unit fields set without a matching unit");

    // Terminal fields are zero without a find
    a_term_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_terminal_found |-> m_terminal_id == 8'd0 && m_focal_min == 16'd0 &&
            m_focal_max == 16'd0 && m_ocular_focal == 16'd0 && !m_zoom_supported)
        else $error("terminal fields set without a camera terminal");

endmodule

bind uvc_descriptor_walker uvcdw_checker u_uvcdw_checker (.*);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for uvc_descriptor_walker. Descriptor streams are built
// mostly from well-formed interface, extension unit and camera terminal
// descriptors with random content. Some streams are pure noise, truncated or
// carry a bad length. A scoreboard class walks the same bytes and predicts
// the end-of-stream result. The GUID registers are reprogrammed between
// phases, and both handshakes stall in random bursts.
// ----------------------------------------------------------------------------

module testbench;

    localparam int NUM_PHASES   = 5;
    localparam int PHASE_BYTES  = 215;
    localparam int MIN_REPORTS  = 40;
    localparam int DRAIN_CYCLES = 4;

    // ------------------------------------------------------------------------
    // Scoreboard: a byte-level walker that predicts each stream's report
    // ------------------------------------------------------------------------
    class walk_checker;
        logic [63:0]   guid_lo;
        logic [63:0]   guid_hi;
        // walk state
        int unsigned   pos;
        logic [7:0]    dlen;
        logic [7:0]    dtype;
        logic [7:0]    subtype;
        logic [7:0]    unit_id;
        logic [7:0]    if_class;
        logic [7:0]    if_subclass;
        logic [7:0]    csize;
        logic [7:0]    ctrl1;
        logic [7:0]    vc_num;
        logic [15:0]   term_type;
        logic [15:0]   fmin;
        logic [15:0]   fmax;
        logic [15:0]   ocular;
        bit            guid_ok;
        bit            in_vc;
        bit            unit_done;
        bit            term_done;
        bit            halted;
        uvcdw_pkg::uvcdw_result_t found;
        // reports still owed by the block, oldest first
        uvcdw_pkg::uvcdw_result_t pending_reports[$];
        int unsigned   bytes_walked;
        int unsigned   streams_closed;
        int unsigned   results_checked;
        int unsigned   mismatches;
        int unsigned   xu_hits;
        int unsigned   term_hits;
        int unsigned   malformed_hits;

        function new();
            guid_lo = uvcdw_pkg::GUID_LOW_RESET;
            guid_hi = uvcdw_pkg::GUID_HIGH_RESET;
            clear_walk();
        endfunction

        function void set_guid(logic [uvcdw_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
            if (idx == uvcdw_pkg::CFG_GUID_LOW) begin
                guid_lo = value;
            end else begin
                guid_hi = value;
            end
        endfunction

        function logic [7:0] guid_at(int unsigned k);
            return (k < 8) ? guid_lo[k*8 +: 8] : guid_hi[(k-8)*8 +: 8];
        endfunction

        function void clear_per_desc();
            dtype       = '0;
            subtype     = '0;
            unit_id     = '0;
            if_class    = '0;
            if_subclass = '0;
            csize       = '0;
            ctrl1       = '0;
            term_type   = '0;
            fmin        = '0;
            fmax        = '0;
            ocular      = '0;
            guid_ok     = 1'b1;
        endfunction

        function void clear_walk();
            pos       = 0;
            dlen      = '0;
            clear_per_desc();
            in_vc     = 1'b0;
            vc_num    = '0;
            unit_done = 1'b0;
            term_done = 1'b0;
            halted    = 1'b0;
            found     = '0;
        endfunction

        // A whole descriptor has been seen: update interface tracking and searches
        function void close_descriptor();
            if (dtype == uvcdw_pkg::DT_INTERFACE && dlen >= uvcdw_pkg::IFACE_MIN_LEN) begin
                in_vc = (if_class == uvcdw_pkg::CLASS_VIDEO) &&
                        (if_subclass == uvcdw_pkg::SUBCLASS_VIDEO_CONTROL);
                if (in_vc) vc_num = subtype;
                return;
            end
            if (dtype != uvcdw_pkg::DT_CLASS_IFACE) return;

            if (!unit_done && dlen >= uvcdw_pkg::UNIT_MIN_LEN &&
                    subtype == uvcdw_pkg::SUB_EXTENSION_UNIT && guid_ok) begin
                found.xu_matched   = 1'b1;
                found.xu_unit_id   = unit_id;
                found.xu_interface = in_vc ? vc_num : 8'h00;
                unit_done          = 1'b1;
            end

            // camera terminal; a control size past the end stops the search empty
            if (!term_done && dlen >= uvcdw_pkg::TERMINAL_BASE_LEN &&
                    subtype == uvcdw_pkg::SUB_INPUT_TERMINAL &&
                    term_type == uvcdw_pkg::TERMINAL_CAMERA) begin
                term_done = 1'b1;
                if (uvcdw_pkg::TERMINAL_BASE_LEN + csize <= dlen) begin
                    found.terminal_found = 1'b1;
                    found.terminal_id    = unit_id;
                    found.focal_min      = fmin;
                    found.focal_max      = fmax;
                    found.ocular_focal   = ocular;
                    found.zoom_supported = (csize > uvcdw_pkg::ZOOM_BIT / 8)
                                           ? ctrl1[uvcdw_pkg::ZOOM_BIT % 8] : 1'b0;
                end
            end
        endfunction

        function void walk_byte(logic [7:0] b, bit last);
            if (halted) return;

            // length byte opens a descriptor; a stream ending here is not an error
            if (pos == 0) begin
                dlen = b;
                clear_per_desc();
                pos  = 1;
                return;
            end
            if (pos == 1) begin
                dtype = b;
                if (dlen < uvcdw_pkg::MIN_DESC_LEN) begin
                    unit_done = 1'b1;
                    term_done = 1'b1;
                    halted    = 1'b1;
                    return;
                end
            end else begin
                // byte offsets within the descriptor
                case (pos)
                    2:  subtype = b;
                    3:  unit_id = b;
                    4:  term_type[7:0] = b;
                    5: begin
                        term_type[15:8] = b;
                        if_class        = b;
                    end
                    6:  if_subclass = b;
                    8:  fmin[7:0] = b;
                    9:  fmin[15:8] = b;
                    10: fmax[7:0] = b;
                    11: fmax[15:8] = b;
                    12: ocular[7:0] = b;
                    13: ocular[15:8] = b;
                    14: csize = b;
                    16: ctrl1 = b;
                    default: ;
                endcase
                if (pos >= 4 && pos <= 19 && b != guid_at(pos - 4)) guid_ok = 1'b0;
            end

            if (pos + 1 >= dlen) begin
                close_descriptor();
                pos = 0;
            end else begin
                pos = pos + 1;
                // stream cut inside a descriptor
                if (last) begin
                    unit_done = 1'b1;
                    term_done = 1'b1;
                    halted    = 1'b1;
                end
            end
        endfunction

        // Accepted input beat
        function void note_byte(logic [7:0] b, bit last);
            uvcdw_pkg::uvcdw_result_t r;
            if (!halted) bytes_walked++;
            walk_byte(b, last);
            if (last) begin
                r           = found;
                r.malformed = halted;
                pending_reports.push_back(r);
                streams_closed++;
                xu_hits        += r.xu_matched;
                term_hits      += r.terminal_found;
                malformed_hits += r.malformed;
                clear_walk();
            end
        endfunction

        task report_mismatch(string what);
            $display("[%0t] MISMATCH %s", $realtime, what);
            mismatches++;
        endtask

        task cmp_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("report %0d %s: got 0x%0h, expected 0x%0h",
                                          results_checked, name, got, want));
            end
        endtask

        // Accepted result beat, compared with the oldest expectation
        task check_result(uvcdw_pkg::uvcdw_result_t got);
            uvcdw_pkg::uvcdw_result_t want;
            if (pending_reports.size() == 0) begin
                report_mismatch("report beat with nothing expected");
                return;
            end
            want = pending_reports.pop_front();
            cmp_field("xu_matched",     got.xu_matched,     want.xu_matched);
            cmp_field("xu_unit_id",     got.xu_unit_id,     want.xu_unit_id);
            cmp_field("xu_interface",   got.xu_interface,   want.xu_interface);
            cmp_field("terminal_found", got.terminal_found, want.terminal_found);
            cmp_field("terminal_id",    got.terminal_id,    want.terminal_id);
            cmp_field("focal_min",      got.focal_min,      want.focal_min);
            cmp_field("focal_max",      got.focal_max,      want.focal_max);
            cmp_field("ocular_focal",   got.ocular_focal,   want.ocular_focal);
            cmp_field("zoom_supported", got.zoom_supported, want.zoom_supported);
            cmp_field("malformed",      got.malformed,      want.malformed);
            results_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic                            aclk              = 1'b0;
    logic                            aresetn           = 1'b0;
    logic                            cfg_wr_en         = 1'b0;
    logic [uvcdw_pkg::CFG_IDX_W-1:0] cfg_index         = '0;
    logic [63:0]                     cfg_wdata         = '0;
    logic                            s_valid           = 1'b0;
    logic                            s_ready;
    logic [7:0]                      s_descriptor_byte = '0;
    logic                            s_last_byte       = 1'b0;
    logic                            m_valid;
    logic                            m_ready           = 1'b0;
    logic                            m_xu_matched;
    logic [7:0]                      m_xu_unit_id;
    logic [7:0]                      m_xu_interface;
    logic                            m_terminal_found;
    logic [7:0]                      m_terminal_id;
    logic [15:0]                     m_focal_min;
    logic [15:0]                     m_focal_max;
    logic [15:0]                     m_ocular_focal;
    logic                            m_zoom_supported;
    logic                            m_malformed;

    walk_checker                     sb;
    uvcdw_pkg::uvcdw_result_t        seen_beat;
    logic [7:0]                      stream_q[$];
    logic [7:0]                      desc_q[$];
    bit                              rx_idle_on = 1'b0;
    int unsigned                     stall_left = 0;
    int unsigned                     guid_settings = 1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    uvc_descriptor_walker i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_descriptor_byte (s_descriptor_byte),
        .s_last_byte       (s_last_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_xu_matched      (m_xu_matched),
        .m_xu_unit_id      (m_xu_unit_id),
        .m_xu_interface    (m_xu_interface),
        .m_terminal_found  (m_terminal_found),
        .m_terminal_id     (m_terminal_id),
        .m_focal_min       (m_focal_min),
        .m_focal_max       (m_focal_max),
        .m_ocular_focal    (m_ocular_focal),
        .m_zoom_supported  (m_zoom_supported),
        .m_malformed       (m_malformed)
    );

    // Result side: m_ready drops in random stall bursts
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_beat = {m_xu_matched, m_xu_unit_id, m_xu_interface, m_terminal_found,
                         m_terminal_id, m_focal_min, m_focal_max, m_ocular_focal,
                         m_zoom_supported, m_malformed};
            sb.check_result(seen_beat);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit last, input int unsigned gap);
        if (gap != 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_descriptor_byte <= b;
        s_last_byte       <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(b, last);
    endtask

    task automatic send_stream(input bit idle_on);
        int unsigned i;
        int unsigned gap;
        for (i = 0; i < stream_q.size(); i++) begin
            gap = (idle_on && $urandom_range(0, 11) == 0) ? $urandom_range(1, 16) : 0;
            send_byte(stream_q[i], i == stream_q.size() - 1, gap);
        end
    endtask

    // Hold off the input until every report is back and the block is quiet
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [uvcdw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_guid(idx, value);
    endtask

    // Phase 1 zeros, phase 2 ones, later phases random
    task automatic program_guid(input int phase);
        logic [63:0] lo;
        logic [63:0] hi;
        case (phase)
            1: begin
                lo = '0;
                hi = '0;
            end
            2: begin
                lo = '1;
                hi = '1;
            end
            default: begin
                lo = {$urandom(), $urandom()};
                hi = {$urandom(), $urandom()};
            end
        endcase
        cfg_write(uvcdw_pkg::CFG_GUID_LOW, lo);
        cfg_write(uvcdw_pkg::CFG_GUID_HIGH, hi);
        guid_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------------
    function automatic void start_desc(int unsigned dlen, logic [7:0] dtype);
        desc_q = {};
        desc_q.push_back(8'(dlen));
        desc_q.push_back(dtype);
        while (desc_q.size() < dlen) desc_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void append_desc();
        foreach (desc_q[i]) stream_q.push_back(desc_q[i]);
    endfunction

    function automatic void add_random_desc();
        int unsigned pick;
        int unsigned dlen;
        int unsigned k;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            // interface, often video control
            dlen = ($urandom_range(0, 9) < 8) ? uvcdw_pkg::IFACE_MIN_LEN
                                              : $urandom_range(2, 12);
            start_desc(dlen, uvcdw_pkg::DT_INTERFACE);
            if (dlen > 5 && $urandom_range(0, 9) < 7) desc_q[5] = uvcdw_pkg::CLASS_VIDEO;
            if (dlen > 6 && $urandom_range(0, 9) < 7) begin
                desc_q[6] = uvcdw_pkg::SUBCLASS_VIDEO_CONTROL;
            end
        end else if (pick < 45) begin
            // extension unit carrying the programmed GUID, sometimes one bit off
            dlen = ($urandom_range(0, 9) != 0)
                ? $urandom_range(uvcdw_pkg::UNIT_MIN_LEN, 26)
                : $urandom_range(2, uvcdw_pkg::UNIT_MIN_LEN - 1);
            start_desc(dlen, uvcdw_pkg::DT_CLASS_IFACE);
            if (dlen > 2 && $urandom_range(0, 9) != 0) desc_q[2] = uvcdw_pkg::SUB_EXTENSION_UNIT;
            for (k = 4; k < dlen && k < 20; k++) desc_q[k] = sb.guid_at(k - 4);
            if (dlen > 4 && $urandom_range(0, 3) == 0) begin
                k = $urandom_range(4, ((dlen < 20) ? dlen : 20) - 1);
                desc_q[k] = desc_q[k] ^ (8'h01 << $urandom_range(0, 7));
            end
        end else if (pick < 70) begin
            // camera terminal; control size sometimes runs past the end
            dlen = ($urandom_range(0, 9) != 0)
                ? $urandom_range(uvcdw_pkg::TERMINAL_BASE_LEN, 22)
                : $urandom_range(2, uvcdw_pkg::TERMINAL_BASE_LEN - 1);
            start_desc(dlen, uvcdw_pkg::DT_CLASS_IFACE);
            if (dlen > 2 && $urandom_range(0, 9) != 0) desc_q[2] = uvcdw_pkg::SUB_INPUT_TERMINAL;
            if (dlen > 5 && $urandom_range(0, 19) > 2) begin
                desc_q[4] = uvcdw_pkg::TERMINAL_CAMERA[7:0];
                desc_q[5] = uvcdw_pkg::TERMINAL_CAMERA[15:8];
            end
            if (dlen > 14) begin
                desc_q[14] = ($urandom_range(0, 9) == 0)
                    ? 8'($urandom_range(0, 255))
                    : 8'($urandom_range(0, dlen - uvcdw_pkg::TERMINAL_BASE_LEN + 1));
            end
        end else if (pick < 99) begin
            dlen = $urandom_range(2, 12);
            start_desc(dlen, ($urandom_range(0, 2) == 0) ? uvcdw_pkg::DT_CLASS_IFACE
                                                         : 8'($urandom_range(0, 255)));
        end else begin
            // rare long descriptor, up to the largest length
            start_desc($urandom_range(200, 255), 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_stream();
        int unsigned n;
        int unsigned ending;
        stream_q = {};
        // plain noise
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 40);
            repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(1, 3);
        repeat (n) begin
            add_random_desc();
            append_desc();
        end
        ending = $urandom_range(0, 99);
        if (ending < 7 && desc_q.size() >= 3) begin
            // cut the last descriptor short, keeping its length and type bytes
            n = $urandom_range(1, desc_q.size() - 2);
            repeat (n) stream_q.delete(stream_q.size() - 1);
        end else if (ending < 12) begin
            // lone trailing length byte
            stream_q.push_back(8'($urandom_range(0, 255)));
        end else if (ending < 16) begin
            // bad length, then bytes the block must ignore
            stream_q.push_back(8'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic run_directed();
        // lone trailing byte
        stream_q = '{8'hFF};
        send_stream(1'b0);
        // zero length
        stream_q = '{8'h00, 8'h24, 8'hFF};
        send_stream(1'b0);
        // interface cut off after its third byte
        stream_q = '{8'h09, 8'h04, 8'h00};
        send_stream(1'b0);
        // minimal descriptor, then a camera terminal whose controls overrun it
        stream_q = '{8'h02, 8'hFF, 8'h0F, 8'h24, 8'h02, 8'h7E, 8'h01, 8'h02, 8'h00,
                     8'h00, 8'h34, 8'h12, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'h01};
        send_stream(1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase;
        int unsigned phase_start;
        bit phase_idle;
        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        rx_idle_on = 1'b1;
        run_directed();
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) program_guid(phase);
            phase_idle  = (phase < NUM_PHASES - 1);
            phase_start = sb.bytes_walked;
            while (sb.bytes_walked - phase_start < PHASE_BYTES
                   || (phase == NUM_PHASES - 1 && sb.streams_closed < MIN_REPORTS)) begin
                build_stream();
                rx_idle_on = phase_idle && ($urandom_range(0, 3) != 0);
                send_stream(phase_idle && ($urandom_range(0, 3) != 0));
                if ($urandom_range(0, 9) == 0) drain();
            end
            drain();
        end
        rx_idle_on = 1'b0;
        repeat (8) @(posedge aclk);

        $display("Covered %0d walked bytes in %0d streams under %0d GUID settings,",
                 sb.bytes_walked, sb.streams_closed, guid_settings);
        $display("%0d reports checked: unit matches %0d, camera terminals %0d, malformed %0d.",
                 sb.results_checked, sb.xu_hits, sb.term_hits, sb.malformed_hits);
        if (sb.mismatches == 0) begin
            $display("uvc_descriptor_walker verification clean");
        end else begin
            $display("uvc_descriptor_walker verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d reports outstanding.", sb.pending_reports.size());
        $display("uvc_descriptor_walker verification failed");
        $finish;
    end

endmodule
